FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold on every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

FILE: hdl/fssh_pkg.sv
// ----------------------------------------------------------------------------
// fssh_pkg
// shared sizes and the query token for the symbol histogram cell chain
// ----------------------------------------------------------------------------
package fssh_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int COUNT_BITS  = 32;

  localparam int SYM_W       = 8;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int DIST_W      = $clog2(TABLE_SLOTS + 1);

  // result field widths on the port
  localparam int SLOT_OUT_W  = 8;
  localparam int COUNT_OUT_W = 32;
  localparam int DIST_OUT_W  = 9;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 56;
  localparam int M_TUSER_W   = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // query token walking the chain, one cell per cycle while the row advances
  typedef struct packed {
    logic                  valid;
    logic [SYM_W-1:0]      symbol;
    logic                  found;      // matched or placed somewhere upstream
    logic                  new_entry;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_BITS-1:0] count;
    logic [DIST_W-1:0]     seen;       // occupied cells passed so far
  } token_t;

endpackage

FILE: hdl/fssh_cell.sv
// ----------------------------------------------------------------------------
// fssh_cell
// one table slot: holds symbol, count and valid bit, updates on the passing
// query token and hands the token on to the next cell
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fssh_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [fssh_pkg::SLOT_W-1:0] slot_idx_i,
  input  fssh_pkg::token_t       tok_i,
  output fssh_pkg::token_t       tok_o
);
  import fssh_pkg::*;

  logic                  valid_q, valid_d;
  logic [SYM_W-1:0]      sym_q, sym_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  token_t                tok_q, tok_d;

  logic                  hit;
  logic                  ins;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign hit     = tok_i.valid && valid_q && (sym_q == tok_i.symbol);
  assign ins     = tok_i.valid && !valid_q && !tok_i.found;
  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_BITS'(1);

  always_comb begin
    valid_d = valid_q;
    sym_d   = sym_q;
    cnt_d   = cnt_q;
    tok_d   = tok_i;
    if (hit) begin
      cnt_d           = cnt_inc;
      tok_d.found     = 1'b1;
      tok_d.slot      = slot_idx_i;
      tok_d.count     = cnt_inc;
    end else if (ins) begin
      valid_d         = 1'b1;
      sym_d           = tok_i.symbol;
      cnt_d           = COUNT_BITS'(1);
      tok_d.found     = 1'b1;
      tok_d.new_entry = 1'b1;
      tok_d.slot      = slot_idx_i;
      tok_d.count     = COUNT_BITS'(1);
    end
    tok_d.seen = tok_i.seen + DIST_W'(valid_q || ins);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      tok_q   <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      tok_q   <= tok_d;
    end
  end

  // symbol store is only read behind the valid bit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sym_q <= sym_d;
    end
  end

  assign tok_o = tok_q;

  `ASSERT_PROP(a_ins_fills, clk_i, rst_ni, en_i && ins |=> valid_q && cnt_q == COUNT_BITS'(1))
  `ASSERT_PROP(a_slot_sticks, clk_i, rst_ni, valid_q |=> valid_q)
  `ASSERT_NEVER(a_new_without_found, clk_i, rst_ni, tok_q.valid && tok_q.new_entry && !tok_q.found)
  `ASSERT_NEVER(a_seen_overflow, clk_i, rst_ni, tok_q.valid && tok_q.seen > DIST_W'(TABLE_SLOTS))

endmodule

FILE: hdl/first_seen_symbol_histogram.sv
// ----------------------------------------------------------------------------
// first_seen_symbol_histogram
// byte histogram in first-seen order, built as a chain of table cells
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (lsb up)                     tuser
//  s_axis    in   symbol[7:0]                               -
//  m_axis    out  slot[7:0] count[39:8] distinct[48:40]     new_entry, dropped
//
//  each symbol travels down the row of TABLE_SLOTS cells, one cell a cycle
//  while the row is not held, and passes the token register of every cell
//  before its result comes out; one new symbol can enter every cycle
//  unless the row is held, and results come out in input order.
//  reset clears every cell's valid bit at once, no sweep is needed.
//  while a result waits with m_axis_tready low the whole row holds still and
//  s_axis_tready drops.
// ----------------------------------------------------------------------------
module first_seen_symbol_histogram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [fssh_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // symbol
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [fssh_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // slot, count, distinct, pad
  output logic [fssh_pkg::M_TUSER_W-1:0] m_axis_tuser_o   // new_entry, dropped
);
  import fssh_pkg::*;

  token_t chain [TABLE_SLOTS+1];
  token_t head;
  logic   advance;
  token_t res;

  // whole row moves when the result slot is free or being taken
  assign advance = !chain[TABLE_SLOTS].valid || m_axis_tready_i;

  always_comb begin
    head        = '0;
    head.valid  = s_axis_tvalid_i;
    head.symbol = s_axis_tdata_i[SYM_W-1:0];
  end

  assign chain[0] = head;

  for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
    fssh_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (advance),
      .slot_idx_i (SLOT_W'(k)),
      .tok_i      (chain[k]),
      .tok_o      (chain[k+1])
    );
  end

  assign res             = chain[TABLE_SLOTS];
  assign s_axis_tready_o = advance;
  assign m_axis_tvalid_o = res.valid;

  // unmatched token at the end means the table was full
  assign m_axis_tdata_o = {
    {(M_TDATA_W - SLOT_OUT_W - COUNT_OUT_W - DIST_OUT_W){1'b0}},
    DIST_OUT_W'(res.seen),
    COUNT_OUT_W'(res.count),
    SLOT_OUT_W'(res.slot)
  };
  assign m_axis_tuser_o = {!res.found, res.new_entry};

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the first-seen byte histogram against a software copy of its table:
// directed edge symbols, then weighted random streams that fill every slot,
// with random stalls on both stream channels
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = fssh_pkg::TABLE_SLOTS + 40;

  typedef struct {
    logic [7:0]  slot;
    logic [31:0] count;
    logic        new_entry;
    logic        dropped;
    logic [8:0]  distinct;
  } tally_t;

  // software copy of the symbol table, one expected tally per accepted symbol
  class histogram_mirror;
    logic [7:0]                      slot_symbol [fssh_pkg::TABLE_SLOTS];
    logic [fssh_pkg::COUNT_BITS-1:0] slot_count  [fssh_pkg::TABLE_SLOTS];
    bit                              slot_valid  [fssh_pkg::TABLE_SLOTS];
    int unsigned                     used_slots;
    tally_t                          expected_tallies [$];
    int unsigned                     mismatches;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_count[i] = '0;
        slot_symbol[i] = '0;
      end
      used_slots = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_tallies.size();
    endfunction

    function void note_symbol(logic [7:0] sym);
      tally_t t;
      int     hit;
      hit = -1;
      t = '{default: '0};
      for (int i = 0; i < int'(used_slots); i++) begin
        if (slot_valid[i] && slot_symbol[i] == sym) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        if (slot_count[hit] != fssh_pkg::COUNT_MAX) slot_count[hit] = slot_count[hit] + 1'b1;
        t.slot     = 8'(hit);
        t.count    = 32'(slot_count[hit]);
        t.distinct = 9'(used_slots);
      end else if (used_slots < fssh_pkg::TABLE_SLOTS) begin
        slot_symbol[used_slots] = sym;
        slot_count[used_slots]  = 1;
        slot_valid[used_slots]  = 1'b1;
        t.slot      = 8'(used_slots);
        t.count     = 32'd1;
        t.new_entry = 1'b1;
        used_slots++;
        t.distinct  = 9'(used_slots);
      end else begin
        t.dropped  = 1'b1;
        t.distinct = 9'(used_slots);
      end
      expected_tallies.push_back(t);
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(tally_t got);
      tally_t want;
      if (expected_tallies.size() == 0) begin
        complain($sformatf("result with nothing expected: slot=%0d count=%0d new=%0b drop=%0b dist=%0d",
                           got.slot, got.count, got.new_entry, got.dropped, got.distinct));
        return;
      end
      want = expected_tallies.pop_front();
      if (got.slot !== want.slot || got.count !== want.count ||
          got.new_entry !== want.new_entry || got.dropped !== want.dropped ||
          got.distinct !== want.distinct)
        complain($sformatf({"expected slot=%0d count=%0d new=%0b drop=%0b dist=%0d, ",
                            "got slot=%0d count=%0d new=%0b drop=%0b dist=%0d"},
                           want.slot, want.count, want.new_entry, want.dropped, want.distinct,
                           got.slot, got.count, got.new_entry, got.dropped, got.distinct));
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [fssh_pkg::S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [fssh_pkg::M_TDATA_W-1:0] m_axis_tdata_o;
  logic [fssh_pkg::M_TUSER_W-1:0] m_axis_tuser_o;

  histogram_mirror histogram = new();
  bit              calm = 1'b0;
  int unsigned     idle_cycles = 0;
  int unsigned     stall_left = 0;

  first_seen_symbol_histogram DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // called and returns at a falling edge
  task automatic send_symbol(input logic [7:0] sym);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sym;
    do @(posedge clk_i); while (!s_axis_tready_o);
    histogram.note_symbol(sym);
    @(negedge clk_i);
  endtask

  // receiver stalls in short bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tally_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.slot      = m_axis_tdata_o[7:0];
      got.count     = m_axis_tdata_o[39:8];
      got.distinct  = m_axis_tdata_o[48:40];
      got.new_entry = m_axis_tuser_o[0];
      got.dropped   = m_axis_tuser_o[1];
      histogram.check_result(got);
    end
    if (!rst_ni || (m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_CYCLES);
    $display("[first_seen_symbol_histogram] ERROR");
    $finish;
  end

  initial begin
    logic [7:0] edge_syms [$];
    logic [7:0] prev_sym;
    logic [7:0] sym;
    int         order [256];
    int         j;
    int         tmp;

    // zero and all-ones first, repeats, then walking ones and zeros
    edge_syms = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                  8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
                  8'h00, 8'h00};

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (edge_syms[i]) send_symbol(edge_syms[i]);

    // growing table: a hot set with back-to-back repeats and fresh symbols
    prev_sym = 8'h00;
    repeat (700) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: sym = 8'($urandom_range(0, 15));
        6, 7:             sym = 8'($urandom_range(0, 255));
        8:                sym = 8'($urandom_range(240, 255));
        default:          sym = prev_sym;
      endcase
      send_symbol(sym);
      prev_sym = sym;
    end

    // hold off until the pipeline has drained
    s_axis_tvalid_i <= 1'b0;
    while (histogram.pending() != 0) @(negedge clk_i);

    // every byte value once in random order fills the table
    foreach (order[i]) order[i] = i;
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) send_symbol(8'(order[i]));

    // full table, every symbol is a hit
    repeat (700) begin
      if ($urandom_range(0, 3) == 0) sym = prev_sym;
      else sym = 8'($urandom_range(0, 255));
      send_symbol(sym);
      prev_sym = sym;
    end

    calm = 1'b1;
    repeat (200) begin
      if ($urandom_range(0, 2) == 0) sym = prev_sym;
      else sym = 8'($urandom_range(0, 255));
      send_symbol(sym);
      prev_sym = sym;
    end
    s_axis_tvalid_i <= 1'b0;

    while (histogram.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (histogram.mismatches == 0 && histogram.pending() == 0)
      $display("[first_seen_symbol_histogram] OK");
    else
      $display("[first_seen_symbol_histogram] ERROR");
    $finish;
  end

endmodule
